FILE: src/fixed_record_ticker_time_filter_macros.svh
// Assertion helpers used by the filter top level; clk and arst_n come from the using scope.
`ifndef FIXED_RECORD_TICKER_TIME_FILTER_MACROS_SVH
`define FIXED_RECORD_TICKER_TIME_FILTER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define FRTF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define FRTF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/frtf_pkg.sv
`default_nettype none

package frtf_pkg;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 7;
	localparam int SECS_W    = 19;
	localparam int IV_W      = 17;
	localparam int TICKER_W  = 40;
	localparam int DATE_W    = 64;
	localparam int CNT_W     = 5;

	// Record layout
	localparam int DATE_START   = 15;
	localparam int TIME_START   = 23;
	localparam int TIME_DIGITS  = 6;
	localparam int POS_MAX      = 127;
	// position after the last time digit has been taken in
	localparam int COMPLETE_POS = TIME_START + TIME_DIGITS;
	localparam int DIV_STEPS    = SECS_W;

	// Configuration register indexes
	localparam logic [1:0] REG_TICKER   = 2'd0;
	localparam logic [1:0] REG_DATE     = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	// Reset values
	localparam logic [TICKER_W-1:0] TICKER_RESET   = 40'd138028458016;
	localparam logic [DATE_W-1:0]   DATE_RESET     = 64'd0;
	localparam logic [IV_W-1:0]     INTERVAL_RESET = 17'd1;

	// Weight of each hhmmss digit in seconds
	localparam logic [15:0] DIGIT_WEIGHT [TIME_DIGITS] =
		'{16'd36000, 16'd3600, 16'd600, 16'd60, 16'd10, 16'd1};

	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	// Controller to datapath
	typedef struct packed {
		logic take;    // byte transfer on the input
		logic start;   // last byte taken, arm the remainder unit
		logic step;    // one remainder iteration
		logic finish;  // evaluate, load the result, clear the record
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/frtf_if.sv
`default_nettype none

// Record byte stream
interface frtf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] record_byte;
	logic       end_of_record;

	modport source (output valid, record_byte, end_of_record, input ready);
	modport sink (input valid, record_byte, end_of_record, output ready);
endinterface

// Per-record result stream
interface frtf_out_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [18:0] time_seconds;
	logic        malformed;

	modport source (output valid, matched, time_seconds, malformed, input ready);
	modport sink (input valid, matched, time_seconds, malformed, output ready);
endinterface

`default_nettype wire

FILE: src/frtf_ctrl.sv
`default_nettype none

module frtf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_eor,
	output logic                in_ready,
	input  wire                 out_ready,
	output logic                out_valid,
	input  frtf_pkg::sts_t      sts,
	output frtf_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_SCAN = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_SCAN: begin
				cmd.take = in_valid;
				if (in_valid && in_eor) begin
					cmd.start = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_SCAN;
				end
			end
			default: begin
				state_nxt = ST_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_SCAN);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: src/frtf_dp.sv
`default_nettype none

module frtf_dp #(
	parameter int TICKER_LENGTH = 5,
	parameter int DATE_LENGTH   = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  frtf_pkg::cmd_t                     cmd,
	output frtf_pkg::sts_t                     sts,
	input  wire [frtf_pkg::BYTE_W-1:0]         record_byte,
	input  wire [frtf_pkg::TICKER_W-1:0]       ticker_chars,
	input  wire [frtf_pkg::DATE_W-1:0]         date_chars,
	input  wire [frtf_pkg::IV_W-1:0]           interval_seconds,
	output logic                               matched,
	output logic [frtf_pkg::SECS_W-1:0]        time_seconds,
	output logic                               malformed
);

	localparam logic [2:0] TICKER_TOP = 3'(TICKER_LENGTH - 1);
	localparam logic [2:0] DATE_TOP   = 3'(DATE_LENGTH - 1);
	localparam int         DATE_END   = frtf_pkg::DATE_START + DATE_LENGTH;
	localparam int         TIME_END   = frtf_pkg::TIME_START + frtf_pkg::TIME_DIGITS;

	// Per-record state
	logic [frtf_pkg::POS_W-1:0]  pos_q;
	logic                        teq_q;
	logic                        deq_q;
	logic                        tdv_q;
	logic [frtf_pkg::SECS_W-1:0] acc_q;
	// Kept across records
	logic [frtf_pkg::SECS_W-1:0] last_q;
	// Remainder unit
	logic [frtf_pkg::IV_W-1:0]   rem_q;
	logic [frtf_pkg::CNT_W-1:0]  cnt_q;
	// Output register
	logic                        matched_q;
	logic [frtf_pkg::SECS_W-1:0] secs_q;
	logic                        malformed_q;

	// Byte decode
	logic                        in_ticker;
	logic                        in_date;
	logic                        in_time;
	logic [frtf_pkg::POS_W-1:0]  date_off;
	logic [frtf_pkg::POS_W-1:0]  time_off;
	logic [2:0]                  tick_sel;
	logic [2:0]                  date_sel;
	logic [63:0]                 tick_ext;
	logic [frtf_pkg::BYTE_W-1:0] tick_ch;
	logic [frtf_pkg::BYTE_W-1:0] date_ch;
	logic                        is_digit;
	logic [15:0]                 weight;
	logic [19:0]                 prod;

	// Remainder step and evaluation
	logic [frtf_pkg::IV_W-1:0]   iv_eff;
	logic [frtf_pkg::IV_W:0]     rem_sh;
	logic [frtf_pkg::IV_W:0]     rem_sub;
	logic                        bad;
	logic [frtf_pkg::SECS_W-1:0] secs;
	logic                        hit;

	// Field windows and the expected characters
	always_comb begin
		in_ticker = (pos_q < frtf_pkg::POS_W'(TICKER_LENGTH));
		in_date   = (pos_q >= frtf_pkg::POS_W'(frtf_pkg::DATE_START)) &&
			(pos_q < frtf_pkg::POS_W'(DATE_END));
		in_time   = (pos_q >= frtf_pkg::POS_W'(frtf_pkg::TIME_START)) &&
			(pos_q < frtf_pkg::POS_W'(TIME_END));
		date_off  = pos_q - frtf_pkg::POS_W'(frtf_pkg::DATE_START);
		time_off  = pos_q - frtf_pkg::POS_W'(frtf_pkg::TIME_START);
		tick_sel  = TICKER_TOP - pos_q[2:0];
		date_sel  = DATE_TOP - date_off[2:0];
		tick_ext  = {24'b0, ticker_chars};
		tick_ch   = tick_ext[{tick_sel, 3'b000} +: 8];
		date_ch   = date_chars[{date_sel, 3'b000} +: 8];
		is_digit  = (record_byte >= frtf_pkg::CHAR_ZERO) &&
			(record_byte <= frtf_pkg::CHAR_NINE);
		weight    = in_time ? frtf_pkg::DIGIT_WEIGHT[time_off[2:0]] : 16'd0;
		prod      = {16'b0, record_byte[3:0]} * {4'b0, weight};
	end

	// Remainder iteration and result
	always_comb begin
		iv_eff  = (interval_seconds == '0) ? frtf_pkg::IV_W'(1) : interval_seconds;
		rem_sh  = {rem_q, acc_q[cnt_q]};
		rem_sub = rem_sh - {1'b0, iv_eff};
		bad     = (pos_q < frtf_pkg::POS_W'(frtf_pkg::COMPLETE_POS)) || !tdv_q;
		secs    = bad ? '0 : acc_q;
		hit     = !bad && teq_q && deq_q && (rem_q == '0) && (secs > last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			teq_q  <= 1'b1;
			deq_q  <= 1'b1;
			tdv_q  <= 1'b1;
			acc_q  <= '0;
			last_q <= '0;
			cnt_q  <= '0;
		end else begin
			// Scan one byte
			if (cmd.take) begin
				if (in_ticker && (record_byte != tick_ch)) begin
					teq_q <= 1'b0;
				end
				if (in_date && (record_byte != date_ch)) begin
					deq_q <= 1'b0;
				end
				if (in_time) begin
					if (is_digit) begin
						acc_q <= acc_q + prod[frtf_pkg::SECS_W-1:0];
					end else begin
						tdv_q <= 1'b0;
					end
				end
				if (pos_q < frtf_pkg::POS_W'(frtf_pkg::POS_MAX)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			// Remainder bit counter
			if (cmd.start) begin
				cnt_q <= frtf_pkg::CNT_W'(frtf_pkg::DIV_STEPS - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			// Close the record
			if (cmd.finish) begin
				if (hit) begin
					last_q <= secs;
				end
				pos_q <= '0;
				teq_q <= 1'b1;
				deq_q <= 1'b1;
				tdv_q <= 1'b1;
				acc_q <= '0;
			end
		end
	end

	// Restoring remainder, one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
		end else if (cmd.step) begin
			if (rem_sh >= {1'b0, iv_eff}) begin
				rem_q <= rem_sub[frtf_pkg::IV_W-1:0];
			end else begin
				rem_q <= rem_sh[frtf_pkg::IV_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			matched_q   <= hit;
			secs_q      <= secs;
			malformed_q <= bad;
		end
	end

	assign sts.div_last = (cnt_q == '0);
	assign matched      = matched_q;
	assign time_seconds = secs_q;
	assign malformed    = malformed_q;

endmodule

`default_nettype wire

FILE: src/fixed_record_ticker_time_filter.sv
// Record filter: one byte transfer per cycle while a record is being scanned.
// After the last byte the remainder unit takes in one seconds bit per step, and then
// the result is loaded into the output register. Input is held off from the last
// byte transfer until the result is loaded, and longer while an earlier result
// still waits on the output.
// arst_n clears record state, last matched time and the configuration registers to their defaults.
`default_nettype none

`include "fixed_record_ticker_time_filter_macros.svh"

module fixed_record_ticker_time_filter #(
	parameter int TICKER_LENGTH = 5,
	parameter int DATE_LENGTH   = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	frtf_in_if.sink      rec,
	frtf_out_if.source   res,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [4:0]   paddr,
	input  wire  [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [frtf_pkg::TICKER_W-1:0] ticker_q;
	logic [frtf_pkg::DATE_W-1:0]   date_q;
	logic [frtf_pkg::IV_W-1:0]     interval_q;
	logic [1:0]                    reg_idx;
	logic                          cfg_wr;

	frtf_pkg::cmd_t cmd;
	frtf_pkg::sts_t sts;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticker_q   <= frtf_pkg::TICKER_RESET;
			date_q     <= frtf_pkg::DATE_RESET;
			interval_q <= frtf_pkg::INTERVAL_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				frtf_pkg::REG_TICKER:   ticker_q   <= pwdata[frtf_pkg::TICKER_W-1:0];
				frtf_pkg::REG_DATE:     date_q     <= pwdata;
				frtf_pkg::REG_INTERVAL: interval_q <= pwdata[frtf_pkg::IV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			frtf_pkg::REG_TICKER:   prdata = {24'b0, ticker_q};
			frtf_pkg::REG_DATE:     prdata = date_q;
			frtf_pkg::REG_INTERVAL: prdata = {47'b0, interval_q};
			default:                prdata = '0;
		endcase
	end

	frtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rec.valid),
		.in_eor    (rec.end_of_record),
		.in_ready  (rec.ready),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	frtf_dp #(
		.TICKER_LENGTH (TICKER_LENGTH),
		.DATE_LENGTH   (DATE_LENGTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.record_byte      (rec.record_byte),
		.ticker_chars     (ticker_q),
		.date_chars       (date_q),
		.interval_seconds (interval_q),
		.matched          (res.matched),
		.time_seconds     (res.time_seconds),
		.malformed        (res.malformed)
	);

	// Checks
	`FRTF_ASSERT_NEXT(a_hold_after_eor, rec.valid && rec.ready && rec.end_of_record, !rec.ready, "input taken right after end of record")
	`FRTF_ASSERT_NOW(a_bad_no_match, res.valid && res.malformed, !res.matched && (res.time_seconds == '0), "malformed record reported a match or time")
	`FRTF_ASSERT_NOW(a_match_nonzero, res.valid && res.matched, res.time_seconds != '0, "match reported at time zero")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS        = 1850;
	localparam int PHASE_BYTES  = 170;
	localparam int CALM_BYTES   = 150;
	localparam int LIMIT        = 500000;
	localparam int DRAIN_CYCLES = 25;
	localparam int HOLD_CYCLES  = 300;
	localparam int TICK_LEN     = 5;
	localparam int DATE_LEN     = 8;

	// index past the end of the register map, writes must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                        matched;
		logic [frtf_pkg::SECS_W-1:0] time_seconds;
		logic                        malformed;
	} verdict_t;

	typedef struct packed {
		logic [frtf_pkg::TICKER_W-1:0] tick;
		logic [frtf_pkg::DATE_W-1:0]   date;
		logic [47:0]                   hms;
		logic [7:0]                    len;
		logic [7:0]                    fill;
		logic                          typed;
		verdict_t                      want;
	} row_t;

	// Directed records, run on the reset settings (interval 1, date all NUL)
	localparam row_t DIR_ROWS [15] = '{
		'{frtf_pkg::TICKER_RESET, 64'd0, "000001", 8'd32, 8'h00, 1'b1, '{1'b1, 19'd1, 1'b0}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000001", 8'd32, 8'hFF, 1'b1, '{1'b0, 19'd1, 1'b0}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000000", 8'd29, 8'h00, 1'b1, '{1'b0, 19'd0, 1'b0}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000010", 8'd5,  8'h00, 1'b1, '{1'b0, 19'd0, 1'b1}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000010", 8'd28, 8'h00, 1'b1, '{1'b0, 19'd0, 1'b1}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000010", 8'd29, 8'hFF, 1'b0, '0},
		'{frtf_pkg::TICKER_RESET, 64'd0, "00:010", 8'd32, 8'h00, 1'b1, '{1'b0, 19'd0, 1'b1}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "0/0020", 8'd32, 8'h00, 1'b1, '{1'b0, 19'd0, 1'b1}},
		'{{frtf_pkg::TICKER_RESET[39:8], 8'h23}, 64'd0, "000100", 8'd32, 8'h00, 1'b0, '0},
		'{frtf_pkg::TICKER_RESET, {56'd0, 8'h39}, "000200", 8'd32, 8'h00, 1'b0, '0},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000300", 8'd140, 8'hFF, 1'b0, '0},
		'{40'hFF_FFFF_FFFF, 64'd0, "999999", 8'd29, 8'h00, 1'b1,
			'{1'b0, 19'd362439, 1'b0}},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000001", 8'd1,  8'h00, 1'b1, '{1'b0, 19'd0, 1'b1}},
		'{frtf_pkg::TICKER_RESET, {64{1'b1}}, "999999", 8'd150, 8'h00, 1'b0, '0},
		'{frtf_pkg::TICKER_RESET, 64'd0, "000400", 8'd31, 8'h00, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	frtf_in_if  rec_if ();
	frtf_out_if res_if ();

	fixed_record_ticker_time_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (rec_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow settings and record state of the filter
	logic [frtf_pkg::TICKER_W-1:0] cfg_ticker;
	logic [frtf_pkg::DATE_W-1:0]   cfg_date;
	logic [frtf_pkg::IV_W-1:0]     cfg_interval;
	logic [frtf_pkg::POS_W-1:0]    scan_pos;
	logic                          ticker_same;
	logic                          date_same;
	logic                          digits_ok;
	logic [frtf_pkg::SECS_W-1:0]   secs_sum;
	logic [frtf_pkg::SECS_W-1:0]   last_hit_secs;

	verdict_t    pending_verdicts [$];
	logic [7:0]  record_buf [$];
	int unsigned bytes_sent;
	int unsigned errors;
	int unsigned cycles;
	bit          calm;
	bit          hold_req;
	verdict_t    oldest;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// Advance the shadow filter by one byte; a verdict comes on the last byte
	task automatic scan_record_byte(input logic [7:0] b, input logic eor,
			output bit has_verdict, output verdict_t v);
		int unsigned p;
		int unsigned iv;
		int unsigned secs;
		bit          bad;
		p = scan_pos;
		v = '0;
		if (p < TICK_LEN && b != cfg_ticker[8*(TICK_LEN-1-p) +: 8])
			ticker_same = 1'b0;
		if (p >= frtf_pkg::DATE_START && p < frtf_pkg::DATE_START + DATE_LEN &&
				b != cfg_date[8*(DATE_LEN-1-(p-frtf_pkg::DATE_START)) +: 8])
			date_same = 1'b0;
		if (p >= frtf_pkg::TIME_START && p < frtf_pkg::TIME_START + frtf_pkg::TIME_DIGITS) begin
			if (b >= frtf_pkg::CHAR_ZERO && b <= frtf_pkg::CHAR_NINE)
				secs_sum = frtf_pkg::SECS_W'(int'(secs_sum) +
					int'(b - frtf_pkg::CHAR_ZERO) *
					int'(frtf_pkg::DIGIT_WEIGHT[p-frtf_pkg::TIME_START]));
			else
				digits_ok = 1'b0;
		end
		if (scan_pos < frtf_pkg::POS_MAX)
			scan_pos = scan_pos + 1'b1;
		has_verdict = eor;
		if (eor) begin
			bad = (p < frtf_pkg::TIME_START + frtf_pkg::TIME_DIGITS - 1) || !digits_ok;
			secs = bad ? 0 : secs_sum;
			iv = (cfg_interval == 0) ? 1 : cfg_interval;
			v.matched = !bad && ticker_same && date_same && (secs % iv) == 0 &&
				secs > last_hit_secs;
			v.time_seconds = frtf_pkg::SECS_W'(secs);
			v.malformed = bad;
			if (v.matched)
				last_hit_secs = frtf_pkg::SECS_W'(secs);
			// per-record state starts over
			scan_pos = '0;
			ticker_same = 1'b1;
			date_same = 1'b1;
			digits_ok = 1'b1;
			secs_sum = '0;
		end
	endtask

	// Lay out ticker, date and hhmmss at their fixed offsets
	task automatic build_record(input logic [frtf_pkg::TICKER_W-1:0] tk,
			input logic [frtf_pkg::DATE_W-1:0] dt, input logic [47:0] hms, input int len,
			input logic [7:0] fill, input bit fill_rand);
		logic [7:0] c;
		record_buf.delete();
		for (int i = 0; i < len; i++) begin
			c = fill_rand ? 8'($urandom_range(0, 255)) : fill;
			if (i < TICK_LEN)
				c = tk[8*(TICK_LEN-1-i) +: 8];
			else if (i >= frtf_pkg::DATE_START && i < frtf_pkg::DATE_START + DATE_LEN)
				c = dt[8*(DATE_LEN-1-(i-frtf_pkg::DATE_START)) +: 8];
			else if (i >= frtf_pkg::TIME_START &&
					i < frtf_pkg::TIME_START + frtf_pkg::TIME_DIGITS)
				c = hms[8*(frtf_pkg::TIME_DIGITS-1-(i-frtf_pkg::TIME_START)) +: 8];
			record_buf.push_back(c);
		end
	endtask

	// Mostly well-formed records aimed at the next sample slot, some noise
	task automatic make_random_record();
		logic [frtf_pkg::TICKER_W-1:0] tk;
		logic [frtf_pkg::DATE_W-1:0]   dt;
		logic [47:0]                   hms;
		logic [7:0]                    c;
		int unsigned                   secs;
		int unsigned                   iv;
		int unsigned                   hh;
		int unsigned                   mm;
		int unsigned                   ss;
		int unsigned                   r;
		int unsigned                   k;
		int unsigned                   len;
		if ($urandom_range(0, 4) == 0) begin
			record_buf.delete();
			len = $urandom_range(1, 40);
			for (int i = 0; i < len; i++)
				record_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			tk = cfg_ticker;
			dt = cfg_date;
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, TICK_LEN - 1);
				tk[8*k +: 8] = tk[8*k +: 8] ^ 8'($urandom_range(1, 255));
			end
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, DATE_LEN - 1);
				dt[8*k +: 8] = dt[8*k +: 8] ^ 8'($urandom_range(1, 255));
			end
			iv = (cfg_interval == 0) ? 1 : cfg_interval;
			r = $urandom_range(0, 9);
			if (r < 6)
				secs = (last_hit_secs / iv + 1 + $urandom_range(0, 2)) * iv;
			else
				secs = $urandom_range(0, 359999);
			if (secs > 359999)
				secs = $urandom_range(0, 359999);
			hh = secs / 3600;
			mm = (secs / 60) % 60;
			ss = secs % 60;
			hms = {frtf_pkg::CHAR_ZERO + 8'(hh / 10), frtf_pkg::CHAR_ZERO + 8'(hh % 10),
				frtf_pkg::CHAR_ZERO + 8'(mm / 10), frtf_pkg::CHAR_ZERO + 8'(mm % 10),
				frtf_pkg::CHAR_ZERO + 8'(ss / 10), frtf_pkg::CHAR_ZERO + 8'(ss % 10)};
			// raw digits reach minutes and seconds past 59
			if (r >= 8)
				for (int i = 0; i < frtf_pkg::TIME_DIGITS; i++)
					hms[8*i +: 8] = frtf_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
			if ($urandom_range(0, 15) == 0) begin
				do
					c = 8'($urandom_range(0, 255));
				while (c >= frtf_pkg::CHAR_ZERO && c <= frtf_pkg::CHAR_NINE);
				k = $urandom_range(0, frtf_pkg::TIME_DIGITS - 1);
				hms[8*k +: 8] = c;
			end
			r = $urandom_range(0, 9);
			if (r < 8)
				len = $urandom_range(29, 40);
			else if (r == 8)
				len = $urandom_range(100, 160);
			else
				len = $urandom_range(20, 28);
			build_record(tk, dt, hms, len, 8'h00, 1'b1);
		end
	endtask

	// One byte transfer, with an optional gap ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eor, input bit steady,
			input bit typed, input verdict_t want);
		bit       has_verdict;
		verdict_t v;
		if (!calm && !steady && $urandom_range(0, 7) == 0) begin
			rec_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.record_byte <= b;
		rec_if.end_of_record <= eor;
		do
			@(posedge clk);
		while (!rec_if.ready);
		bytes_sent++;
		scan_record_byte(b, eor, has_verdict, v);
		if (has_verdict)
			pending_verdicts.push_back(typed ? want : v);
	endtask

	task automatic send_record(input bit typed, input verdict_t want);
		bit steady;
		steady = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < record_buf.size(); i++)
			send_byte(record_buf[i], i == record_buf.size() - 1, steady, typed, want);
	endtask

	// APB write: setup then access, then back to idle
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			frtf_pkg::REG_TICKER:   cfg_ticker = val[frtf_pkg::TICKER_W-1:0];
			frtf_pkg::REG_DATE:     cfg_date = val[frtf_pkg::DATE_W-1:0];
			frtf_pkg::REG_INTERVAL: cfg_interval = val[frtf_pkg::IV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [63:0] want);
		logic [63:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			report_mismatch("register readback", got, want);
	endtask

	// Settings of each phase; big intervals come late so that samples stay reachable
	task automatic load_settings(input int unsigned phase);
		logic [frtf_pkg::TICKER_W-1:0] tk;
		logic [frtf_pkg::DATE_W-1:0]   dt;
		logic [frtf_pkg::IV_W-1:0]     iv;
		int unsigned                   letters;
		letters = $urandom_range(1, TICK_LEN);
		for (int i = 0; i < TICK_LEN; i++)
			tk[8*(TICK_LEN-1-i) +: 8] = (i < letters) ? 8'h41 + 8'($urandom_range(0, 25))
				: 8'h20;
		for (int i = 0; i < DATE_LEN; i++)
			dt[8*i +: 8] = frtf_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
		iv = ($urandom_range(0, 3) == 0) ? frtf_pkg::IV_W'($urandom_range(1, 900))
			: frtf_pkg::IV_W'($urandom_range(1, 120));
		case (phase)
			0: iv = 1;
			1: iv = 0;
			3: begin
				tk = '0;
				dt = '1;
				iv = 60;
			end
			4: begin
				tk = '1;
				dt = '0;
			end
			5: iv = 86400;
			6: iv = '1;
			default: ;
		endcase
		reg_write(frtf_pkg::REG_TICKER, {24'($urandom), tk});
		reg_write(frtf_pkg::REG_DATE, dt);
		reg_write(frtf_pkg::REG_INTERVAL, {47'({$urandom, $urandom}), iv});
		if (phase == 4 || $urandom_range(0, 2) == 0)
			reg_write(REG_SPARE, {$urandom, $urandom});
		reg_check(frtf_pkg::REG_TICKER, 64'(cfg_ticker));
		reg_check(frtf_pkg::REG_DATE, cfg_date);
		reg_check(frtf_pkg::REG_INTERVAL, 64'(cfg_interval));
	endtask

	// Result receiver: random stalls, one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result transfer with the oldest pending verdict
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with none pending", {res_if.matched,
					res_if.time_seconds, res_if.malformed}, 64'd0);
			end else begin
				oldest = pending_verdicts.pop_front();
				if (res_if.matched !== oldest.matched)
					report_mismatch("matched", res_if.matched, oldest.matched);
				if (res_if.time_seconds !== oldest.time_seconds)
					report_mismatch("time_seconds", res_if.time_seconds, oldest.time_seconds);
				if (res_if.malformed !== oldest.malformed)
					report_mismatch("malformed", res_if.malformed, oldest.malformed);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned stop_at;
		int unsigned phase_end;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rec_if.valid = 1'b0;
		rec_if.record_byte = '0;
		rec_if.end_of_record = 1'b0;
		cfg_ticker = frtf_pkg::TICKER_RESET;
		cfg_date = frtf_pkg::DATE_RESET;
		cfg_interval = frtf_pkg::INTERVAL_RESET;
		scan_pos = '0;
		ticker_same = 1'b1;
		date_same = 1'b1;
		digits_ok = 1'b1;
		secs_sum = '0;
		last_hit_secs = '0;
		bytes_sent = 0;
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed records on the reset settings
		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			build_record(DIR_ROWS[i].tick, DIR_ROWS[i].date, DIR_ROWS[i].hms,
				DIR_ROWS[i].len, DIR_ROWS[i].fill, 1'b0);
			send_record(DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		// random phases, new settings written once the filter has drained
		stop_at = ITEMS;
		phase = 0;
		while (bytes_sent < stop_at) begin
			rec_if.valid <= 1'b0;
			while (pending_verdicts.size() != 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			load_settings(phase);
			if (phase == 1)
				hold_req = 1'b1;
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end && bytes_sent < stop_at) begin
				calm = (bytes_sent + CALM_BYTES >= stop_at);
				make_random_record();
				send_record(1'b0, '0);
			end
			phase++;
		end

		rec_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
